// ===== design/psd_pkg.sv =====
// Package for the PNG scanline defilter: filter type codes, size defaults
// and the Paeth predictor. No dependencies.
package psd_pkg;

	localparam int MAX_ROW_BYTES_DEF   = 8192;
	localparam int MAX_PIXEL_BYTES_DEF = 8;

	localparam int BYTE_W  = 8;
	localparam int BPP_W   = 4;
	localparam int ROWB_W  = 14;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 14;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BYTES_PER_PIXEL = 1'b0,
		REG_ROW_BYTES       = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filter_t;

	// Pick whichever of left, up and upper-left lies closest to left+up-upper_left.
	function automatic logic [BYTE_W-1:0] paeth_predict(
		input logic [BYTE_W-1:0] a,
		input logic [BYTE_W-1:0] b,
		input logic [BYTE_W-1:0] c
	);
		logic signed [10:0] sa, sb, sc, p, da, db, dc;
		logic [10:0] pa, pb, pc;
		sa = $signed({3'b000, a});
		sb = $signed({3'b000, b});
		sc = $signed({3'b000, c});
		p  = sa + sb - sc;
		da = p - sa;
		db = p - sb;
		dc = p - sc;
		pa = (da < 0) ? 11'(-da) : 11'(da);
		pb = (db < 0) ? 11'(-db) : 11'(db);
		pc = (dc < 0) ? 11'(-dc) : 11'(dc);
		if (pa <= pb && pa <= pc) begin
			paeth_predict = a;
		end else if (pb <= pc) begin
			paeth_predict = b;
		end else begin
			paeth_predict = c;
		end
	endfunction

endpackage

// ===== design/psd_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered
// read data that holds while no read is enabled. No dependencies.
module psd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/png_scanline_defilter.sv =====
// PNG scanline defilter top level.
// Channels: slave stream s_* carries one byte of the inflated PNG stream per
// transaction (tuser marks the filter byte of an image's first row); master
// stream m_* returns one reconstructed byte per filtered data byte, tlast on
// the final byte of each row, tuser set on the single error result that a
// filter type above 4 produces. Filter bytes and bytes dropped after an error
// give no result. The cfg_* channel writes bytes_per_pixel (index 0) and
// row_bytes (index 1); it is always ready. The user must write it only while
// idle; the block does not enforce this. A data byte is registered in the
// compute stage, with the prior-row store read, then in the output register.
// Throughput: one byte per clock sustained while m_tready stays high; the store
// is read at accept and written when the byte leaves the compute stage, and
// consecutive data bytes use different columns, so no interlock is needed.
// Reset (arst_n low): clears control state, both neighbor histories and
// the registers (to 1); the prior-row store is not cleared, and the first row
// of every image never uses it.
// Stall: when m_tready is low the result holds in the output register, one
// more byte may sit in the compute stage, then s_tready drops.
// Depends on psd_pkg and psd_ram.
module png_scanline_defilter #(
	parameter int MAX_ROW_BYTES   = psd_pkg::MAX_ROW_BYTES_DEF,
	parameter int MAX_PIXEL_BYTES = psd_pkg::MAX_PIXEL_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [psd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [psd_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [psd_pkg::BYTE_W-1:0]        s_tdata,   // [7:0] data_byte
	input  logic                              s_tuser,   // [0] start_of_image
	// output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [psd_pkg::BYTE_W-1:0]        m_tdata,   // [7:0] pixel_byte
	output logic                              m_tlast,   // last_in_row
	output logic                              m_tuser    // [0] bad_filter
);
	import psd_pkg::*;

	localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
	localparam int CNT_W  = $clog2(MAX_ROW_BYTES + 1);
	localparam int HIST_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

	// ---------------- configuration registers ----------------
	logic [BPP_W-1:0]  bpp_q;
	logic [ROWB_W-1:0] row_bytes_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q       <= BPP_W'(1);
			row_bytes_q <= ROWB_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_BYTES_PER_PIXEL: bpp_q       <= cfg_data[BPP_W-1:0];
				REG_ROW_BYTES:       row_bytes_q <= cfg_data[ROWB_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp out-of-range register values into the supported span.
	logic [BPP_W-1:0] bpp_eff;
	logic [CNT_W-1:0] len_eff;

	always_comb begin
		if (bpp_q == '0) begin
			bpp_eff = BPP_W'(1);
		end else if (32'(bpp_q) > 32'(MAX_PIXEL_BYTES)) begin
			bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
		end else begin
			bpp_eff = bpp_q;
		end
		if (row_bytes_q == '0) begin
			len_eff = CNT_W'(1);
		end else if (32'(row_bytes_q) > 32'(MAX_ROW_BYTES)) begin
			len_eff = CNT_W'(MAX_ROW_BYTES);
		end else begin
			len_eff = CNT_W'(row_bytes_q);
		end
	end

	// ---------------- row control state (updated at accept) ----------------
	logic             halted_q;
	logic             first_row_q;
	logic [CNT_W-1:0] col_cnt_q;
	filter_t          filter_q;

	// Compute stage and output register handshakes.
	logic s1_valid_q;
	logic s1_fire;
	logic out_valid_q;
	logic in_accept;

	assign s1_fire   = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready  = !s1_valid_q || s1_fire;
	assign in_accept = s_tvalid && s_tready;

	// Start of image abandons the current row and clears the halt.
	logic             halted_eff;
	logic             first_eff;
	logic [CNT_W-1:0] cnt_eff;
	logic             is_filter_byte;
	logic             is_data_byte;
	logic             is_bad_filter;
	logic [ADDR_W-1:0] col;
	logic             row_end;

	always_comb begin
		halted_eff     = s_tuser ? 1'b0 : halted_q;
		first_eff      = s_tuser ? 1'b1 : first_row_q;
		cnt_eff        = s_tuser ? '0 : col_cnt_q;
		is_filter_byte = !halted_eff && (cnt_eff == '0);
		is_bad_filter  = is_filter_byte && (s_tdata > BYTE_W'(FILT_PAETH));
		is_data_byte   = !halted_eff && (cnt_eff != '0);
		col            = ADDR_W'(cnt_eff - CNT_W'(1));
		row_end        = (cnt_eff >= len_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q    <= 1'b0;
			first_row_q <= 1'b1;
			col_cnt_q   <= '0;
			filter_q    <= FILT_NONE;
		end else if (in_accept) begin
			halted_q    <= halted_eff;
			first_row_q <= first_eff;
			col_cnt_q   <= cnt_eff;
			if (is_bad_filter) begin
				halted_q <= 1'b1;
			end else if (is_filter_byte) begin
				filter_q  <= filter_t'(s_tdata[2:0]);
				col_cnt_q <= CNT_W'(1);
			end else if (is_data_byte) begin
				if (row_end) begin
					col_cnt_q   <= '0;
					first_row_q <= 1'b0;
				end else begin
					col_cnt_q <= cnt_eff + CNT_W'(1);
				end
			end
		end
	end

	// ---------------- compute stage s1 ----------------
	logic              s1_err_s1;
	logic [BYTE_W-1:0] s1_byte_s1;
	filter_t           s1_filter_s1;
	logic              s1_last_s1;
	logic              s1_use_a_s1;
	logic              s1_use_b_s1;
	logic              s1_use_c_s1;
	logic [HIST_W-1:0] s1_hidx_s1;
	logic [ADDR_W-1:0] s1_col_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= is_bad_filter || is_data_byte;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Payload: neighbor selection decided at accept, used in the compute stage.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			s1_err_s1    <= is_bad_filter;
			s1_byte_s1   <= s_tdata;
			s1_filter_s1 <= filter_q;
			s1_last_s1   <= row_end;
			s1_use_a_s1  <= 32'(col) >= 32'(bpp_eff);
			s1_use_b_s1  <= !first_eff;
			s1_use_c_s1  <= (32'(col) >= 32'(bpp_eff)) && !first_eff;
			s1_hidx_s1   <= HIST_W'(bpp_eff - BPP_W'(1));
			s1_col_s1    <= col;
		end
	end

	// Prior-row store: read at accept, written back when the byte leaves s1.
	logic              ram_rd_en;
	logic [BYTE_W-1:0] ram_rd_data;
	logic              ram_wr_en;
	logic [BYTE_W-1:0] recon;

	assign ram_rd_en = in_accept && is_data_byte;
	assign ram_wr_en = s1_fire && !s1_err_s1;

	psd_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_ROW_BYTES)
	) u_prior_row (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (s1_col_s1),
		.wr_data (recon),
		.rd_en   (ram_rd_en),
		.rd_addr (col),
		.rd_data (ram_rd_data)
	);

	// Left and upper-left histories: the last MAX_PIXEL_BYTES reconstructed bytes and the prior-row bytes above them.
	logic [BYTE_W-1:0] left_q   [MAX_PIXEL_BYTES];
	logic [BYTE_W-1:0] corner_q [MAX_PIXEL_BYTES];

	logic [BYTE_W-1:0] nb_a, nb_b, nb_c, pred;
	logic [BYTE_W:0]   avg_sum;

	always_comb begin
		nb_a    = s1_use_a_s1 ? left_q[s1_hidx_s1]   : '0;
		nb_b    = s1_use_b_s1 ? ram_rd_data          : '0;
		nb_c    = s1_use_c_s1 ? corner_q[s1_hidx_s1] : '0;
		avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
		case (s1_filter_s1)
			FILT_NONE:  pred = '0;
			FILT_SUB:   pred = nb_a;
			FILT_UP:    pred = nb_b;
			FILT_AVG:   pred = avg_sum[BYTE_W:1];
			FILT_PAETH: pred = paeth_predict(nb_a, nb_b, nb_c);
			default:    pred = '0;
		endcase
		recon = s1_byte_s1 + pred;
	end

	// Shift the histories on every reconstructed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
				left_q[i]   <= '0;
				corner_q[i] <= '0;
			end
		end else if (ram_wr_en) begin
			left_q[0]   <= recon;
			corner_q[0] <= nb_b;
			for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
				left_q[i]   <= left_q[i-1];
				corner_q[i] <= corner_q[i-1];
			end
		end
	end

	// ---------------- output register ----------------
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;
	logic              out_bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// An error result carries a zero byte and no row end.
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_byte_q <= s1_err_s1 ? '0 : recon;
			out_last_q <= !s1_err_s1 && s1_last_s1;
			out_bad_q  <= s1_err_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_bad_q;

`ifndef SYNTHESIS
	// Store read and write-back never touch the same column in one cycle.
	a_no_store_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_rd_en && ram_wr_en) |-> (col != s1_col_s1))
		else $error("prior-row store read and write hit the same column");

	// A byte taken while halted, without start of image, yields nothing.
	a_halted_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && halted_q && !s_tuser) |=> !s1_valid_q)
		else $error("byte accepted while halted produced a result");

	// A stalled compute stage keeps its byte and column.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_fire) |=>
			(s1_valid_q && $stable(s1_col_s1) && $stable(s1_byte_s1)))
		else $error("compute stage lost its item under stall");

	// Error results never mark a row end and carry a zero byte.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (!m_tlast && (m_tdata == '0)))
		else $error("malformed error result");
`endif

endmodule
